// ===== src/sdc_pkg.sv =====
// shared types, sizes and helpers for the sorted dictionary coder
// no dependencies; used by sdc_cell, sdc_group and sorted_dictionary_coder
package sdc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned GRP_SIZE    = 32;
  localparam int unsigned LOC_W       = $clog2(GRP_SIZE);
  localparam int unsigned N_GRP       = TABLE_DEPTH / GRP_SIZE;
  localparam int unsigned GRP_W       = $clog2(N_GRP);

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_INVERSE = 2'd3
  } req_e;

  typedef struct packed {
    logic              any;
    logic [LOC_W-1:0]  loc;
    logic              eq;
    logic [DATA_W-1:0] rd;
  } grp_t;

  function automatic logic [1:0] width_code_of(input logic [CNT_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    if (w < 32'(1 << 8)) begin
      return WIDTH_8;
    end
    if (w < 32'(1 << 16)) begin
      return WIDTH_16;
    end
    return WIDTH_32;
  endfunction

endpackage

// ===== src/sdc_cell.sv =====
// one table cell: holds an entry, compares it with the key, shifts right on insert
// depends on sdc_pkg
module sdc_cell (
  input  logic                              clk_i,
  input  logic                              cmp_en_i,
  input  logic                              shift_en_i,
  input  logic [sdc_pkg::DATA_W-1:0]        key_i,
  input  logic [sdc_pkg::IDX_W-1:0]         cell_idx_i,
  input  logic [sdc_pkg::CNT_W-1:0]         count_i,
  input  logic [sdc_pkg::IDX_W-1:0]         sel_idx_i,
  input  logic [sdc_pkg::DATA_W-1:0]        left_val_i,
  input  logic                              left_lt_i,
  output logic [sdc_pkg::DATA_W-1:0]        val_o,
  output logic                              lt_o,
  output logic                              eq_o,
  output logic                              hit_o,
  output logic [sdc_pkg::DATA_W-1:0]        rd_o
);

  logic [sdc_pkg::DATA_W-1:0] value_q;
  logic                       lt_q;
  logic                       eq_q;
  logic                       sel_q;
  logic                       occ;

  assign occ = {1'b0, cell_idx_i} < count_i;

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      lt_q  <= occ && (value_q < key_i);
      eq_q  <= occ && (value_q == key_i);
      sel_q <= cell_idx_i == sel_idx_i;
    end
    if (shift_en_i && !lt_q) begin
      value_q <= left_lt_i ? key_i : left_val_i;
    end
  end

  assign val_o = value_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;
  assign hit_o = left_lt_i && !lt_q;
  assign rd_o  = sel_q ? value_q : '0;

endmodule

// ===== src/sdc_group.sv =====
// registered reduction of one group of cells: boundary position, match and read data
// depends on sdc_pkg
module sdc_group (
  input  logic                                             clk_i,
  input  logic [sdc_pkg::GRP_SIZE-1:0]                     hit_i,
  input  logic [sdc_pkg::GRP_SIZE-1:0]                     eq_i,
  input  logic [sdc_pkg::GRP_SIZE-1:0][sdc_pkg::DATA_W-1:0] rd_i,
  output sdc_pkg::grp_t                                    grp_o
);

  sdc_pkg::grp_t grp_d;
  sdc_pkg::grp_t grp_q;

  always_comb begin
    grp_d.any = |hit_i;
    grp_d.eq  = |eq_i;
    grp_d.loc = '0;
    grp_d.rd  = '0;
    for (int k = 0; k < sdc_pkg::GRP_SIZE; k++) begin
      if (hit_i[k]) begin
        grp_d.loc = grp_d.loc | sdc_pkg::LOC_W'(k);
      end
      grp_d.rd = grp_d.rd | rd_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

// ===== src/sorted_dictionary_coder.sv =====
// top level: chain of table cells, group reducers and the request sequencer
// depends on sdc_pkg, sdc_cell, sdc_group
//
// Each item taken (start high, busy low) passes through the compare, group and final
// states, then done_o is raised for one cycle. busy stays high through those states, so no
// new item is taken while one is in flight; the next can be taken in the cycle its
// predecessor's result is shown. The steps: take the item, compare the key against every
// cell of the 1024-entry chain, encode the boundary inside each 32-cell group, combine the
// groups and shift the chain right by one place on an insert that adds an entry.
// The result cannot be held off; it stays on the outputs until the next item finishes.
// cfg_ready_o is high whenever busy is low; the table needs no clearing pass after reset.
module sorted_dictionary_coder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [sdc_pkg::DATA_W-1:0]    data_value_i,
  input  logic [sdc_pkg::IDX_W-1:0]     table_index_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  output logic                          done_o,
  output logic [sdc_pkg::CNT_W-1:0]     rank_index_o,
  output logic [sdc_pkg::DATA_W-1:0]    table_value_o,
  output logic [sdc_pkg::CNT_W-1:0]     entry_count_o,
  output logic [1:0]                    width_code_o,
  output logic                          found_o,
  output logic                          overflow_o,
  output logic                          index_bad_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_FIN
  } state_e;

  state_e                                                       state_q;
  sdc_pkg::req_e                                                req_q;
  logic [sdc_pkg::DATA_W-1:0]                                   key_q;
  logic [sdc_pkg::IDX_W-1:0]                                    idx_q;
  logic [sdc_pkg::CNT_W-1:0]                                    count_q;
  logic                                                         en_q;
  logic                                                         done_q;
  logic [sdc_pkg::CNT_W-1:0]                                    rank_q;
  logic [sdc_pkg::DATA_W-1:0]                                   tval_q;
  logic [sdc_pkg::CNT_W-1:0]                                    ecount_q;
  logic [1:0]                                                   wcode_q;
  logic                                                         found_q;
  logic                                                         ovf_q;
  logic                                                         bad_q;

  logic [sdc_pkg::TABLE_DEPTH-1:0][sdc_pkg::DATA_W-1:0]         cell_val;
  logic [sdc_pkg::TABLE_DEPTH-1:0][sdc_pkg::DATA_W-1:0]         cell_rd;
  logic [sdc_pkg::TABLE_DEPTH-1:0]                              cell_lt;
  logic [sdc_pkg::TABLE_DEPTH-1:0]                              cell_eq;
  logic [sdc_pkg::TABLE_DEPTH-1:0]                              cell_hit;
  sdc_pkg::grp_t                                                grp [sdc_pkg::N_GRP];

  logic                                                         accept;
  logic                                                         cmp_en;
  logic                                                         shift_en;
  logic                                                         any_all;
  logic                                                         found_all;
  logic [sdc_pkg::IDX_W-1:0]                                    enc_all;
  logic [sdc_pkg::DATA_W-1:0]                                   rd_all;
  logic [sdc_pkg::CNT_W-1:0]                                    rank_all;
  logic                                                         full;
  logic                                                         ins_ok;
  logic                                                         idx_bad;
  logic [sdc_pkg::CNT_W-1:0]                                    count_d;

  assign busy        = state_q != ST_IDLE;
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign cmp_en      = state_q == ST_CMP;

  // cell chain
  for (genvar i = 0; i < sdc_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      sdc_cell u_cell (
        .clk_i      (clk_i),
        .cmp_en_i   (cmp_en),
        .shift_en_i (shift_en),
        .key_i      (key_q),
        .cell_idx_i (sdc_pkg::IDX_W'(i)),
        .count_i    (count_q),
        .sel_idx_i  (idx_q),
        .left_val_i (key_q),
        .left_lt_i  (1'b1),
        .val_o      (cell_val[i]),
        .lt_o       (cell_lt[i]),
        .eq_o       (cell_eq[i]),
        .hit_o      (cell_hit[i]),
        .rd_o       (cell_rd[i])
      );
    end else begin : g_rest
      sdc_cell u_cell (
        .clk_i      (clk_i),
        .cmp_en_i   (cmp_en),
        .shift_en_i (shift_en),
        .key_i      (key_q),
        .cell_idx_i (sdc_pkg::IDX_W'(i)),
        .count_i    (count_q),
        .sel_idx_i  (idx_q),
        .left_val_i (cell_val[i-1]),
        .left_lt_i  (cell_lt[i-1]),
        .val_o      (cell_val[i]),
        .lt_o       (cell_lt[i]),
        .eq_o       (cell_eq[i]),
        .hit_o      (cell_hit[i]),
        .rd_o       (cell_rd[i])
      );
    end
  end

  // per-group reduction
  for (genvar g = 0; g < sdc_pkg::N_GRP; g++) begin : g_grp
    sdc_group u_group (
      .clk_i (clk_i),
      .hit_i (cell_hit[g*sdc_pkg::GRP_SIZE +: sdc_pkg::GRP_SIZE]),
      .eq_i  (cell_eq[g*sdc_pkg::GRP_SIZE +: sdc_pkg::GRP_SIZE]),
      .rd_i  (cell_rd[g*sdc_pkg::GRP_SIZE +: sdc_pkg::GRP_SIZE]),
      .grp_o (grp[g])
    );
  end

  always_comb begin
    any_all   = 1'b0;
    found_all = 1'b0;
    enc_all   = '0;
    rd_all    = '0;
    for (int g = 0; g < sdc_pkg::N_GRP; g++) begin
      any_all   = any_all | grp[g].any;
      found_all = found_all | grp[g].eq;
      rd_all    = rd_all | grp[g].rd;
      if (grp[g].any) begin
        enc_all = enc_all | {sdc_pkg::GRP_W'(g), grp[g].loc};
      end
    end
  end

  // no boundary only when every held entry is below the key and the table is full
  assign rank_all = any_all ? {1'b0, enc_all} : sdc_pkg::CNT_W'(sdc_pkg::TABLE_DEPTH);
  assign full     = count_q >= sdc_pkg::CNT_W'(sdc_pkg::TABLE_DEPTH);
  assign ins_ok   = (req_q == sdc_pkg::REQ_INSERT) && !found_all && !full;
  assign shift_en = (state_q == ST_FIN) && ins_ok;
  assign idx_bad  = {1'b0, idx_q} >= count_q;

  always_comb begin
    count_d = count_q;
    unique case (req_q)
      sdc_pkg::REQ_CLEAR:   count_d = '0;
      sdc_pkg::REQ_INSERT:  count_d = ins_ok ? count_q + 1'b1 : count_q;
      sdc_pkg::REQ_LOOKUP:  count_d = count_q;
      sdc_pkg::REQ_INVERSE: count_d = count_q;
      default:              count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      req_q    <= sdc_pkg::REQ_CLEAR;
      key_q    <= '0;
      idx_q    <= '0;
      count_q  <= '0;
      en_q     <= 1'b1;
      done_q   <= 1'b0;
      rank_q   <= '0;
      tval_q   <= '0;
      ecount_q <= '0;
      wcode_q  <= sdc_pkg::WIDTH_8;
      found_q  <= 1'b0;
      ovf_q    <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q   <= sdc_pkg::req_e'(req_type_i);
            key_q   <= data_value_i;
            idx_q   <= table_index_i;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_q <= ST_GRP;
        end
        ST_GRP: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q  <= ST_IDLE;
          done_q   <= 1'b1;
          count_q  <= count_d;
          ecount_q <= count_d;
          wcode_q  <= sdc_pkg::width_code_of(count_d);
          rank_q   <= '0;
          tval_q   <= '0;
          found_q  <= 1'b0;
          ovf_q    <= 1'b0;
          bad_q    <= 1'b0;
          unique case (req_q)
            sdc_pkg::REQ_CLEAR: begin
            end
            sdc_pkg::REQ_INSERT: begin
              rank_q  <= rank_all;
              found_q <= found_all;
              ovf_q   <= !found_all && full;
            end
            sdc_pkg::REQ_LOOKUP: begin
              if (en_q) begin
                rank_q  <= rank_all;
                found_q <= found_all;
              end else begin
                rank_q <= key_q[sdc_pkg::CNT_W-1:0];
                tval_q <= key_q;
              end
            end
            sdc_pkg::REQ_INVERSE: begin
              rank_q <= {1'b0, idx_q};
              if (en_q) begin
                bad_q  <= idx_bad;
                tval_q <= idx_bad ? '0 : rd_all;
              end else begin
                tval_q <= sdc_pkg::DATA_W'(idx_q);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign rank_index_o  = rank_q;
  assign table_value_o = tval_q;
  assign entry_count_o = ecount_q;
  assign width_code_o  = wcode_q;
  assign found_o       = found_q;
  assign overflow_o    = ovf_q;
  assign index_bad_o   = bad_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sdc_pkg::CNT_W'(sdc_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_FIN)
    else $error("result strobe without a final step");

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CMP)
    else $error("accepted item did not enter compare");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_o |-> !found_o && entry_count_o == sdc_pkg::CNT_W'(sdc_pkg::TABLE_DEPTH))
    else $error("overflow flagged on a table that is not full");

  a_bad_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_bad_o |-> table_value_o == '0)
    else $error("bad index returned data");
`endif

endmodule

// ===== tb/sorted_dictionary_coder_checker.sv =====
// result checker for sorted_dictionary_coder: keeps its own sorted table and
// predicts every result, then compares field by field in order of acceptance
// depends on sdc_pkg
`timescale 1ns / 100ps

module sorted_dictionary_coder_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [sdc_pkg::DATA_W-1:0] data_value_i,
  input  logic [sdc_pkg::IDX_W-1:0]  table_index_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic                       cfg_data_i,
  input  logic                       done_i,
  input  logic [sdc_pkg::CNT_W-1:0]  rank_index_i,
  input  logic [sdc_pkg::DATA_W-1:0] table_value_i,
  input  logic [sdc_pkg::CNT_W-1:0]  entry_count_i,
  input  logic [1:0]                 width_code_i,
  input  logic                       found_i,
  input  logic                       overflow_i,
  input  logic                       index_bad_i,
  output int unsigned                mismatches_o,
  output int unsigned                outstanding_o,
  output int unsigned                checked_o
);

  typedef struct packed {
    logic [sdc_pkg::CNT_W-1:0]  rank;
    logic [sdc_pkg::DATA_W-1:0] value;
    logic [sdc_pkg::CNT_W-1:0]  count;
    logic [1:0]                 wcode;
    logic                       hit;
    logic                       ovf;
    logic                       bad;
  } coded_result_t;

  logic [sdc_pkg::DATA_W-1:0] dict [sdc_pkg::TABLE_DEPTH];
  int unsigned                dict_count;
  logic                       xform_on;
  coded_result_t              pending_q [$];
  coded_result_t              oldest;
  coded_result_t              fresh;

  task automatic report_mismatch(input string what, input logic [sdc_pkg::DATA_W-1:0] got,
                                 input logic [sdc_pkg::DATA_W-1:0] want);
    if (mismatches_o < 100) begin
      $display("%0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  // lower-bound position of v among the held entries
  function automatic int unsigned rank_of(input logic [sdc_pkg::DATA_W-1:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = dict_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (dict[mid] < v) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic coded_result_t encode_request(input sdc_pkg::req_e kind,
                                                   input logic [sdc_pkg::DATA_W-1:0] v,
                                                   input logic [sdc_pkg::IDX_W-1:0] ix);
    coded_result_t r;
    int unsigned   pos;
    int unsigned   k;
    r = '0;
    case (kind)
      sdc_pkg::REQ_CLEAR: begin
        dict_count = 0;
      end
      sdc_pkg::REQ_INSERT: begin
        pos    = rank_of(v);
        r.rank = sdc_pkg::CNT_W'(pos);
        if (pos < dict_count && dict[pos] == v) begin
          r.hit = 1'b1;
        end else if (dict_count >= sdc_pkg::TABLE_DEPTH) begin
          r.ovf = 1'b1;
        end else begin
          for (k = dict_count; k > pos; k--) begin
            dict[k] = dict[k-1];
          end
          dict[pos] = v;
          dict_count++;
        end
      end
      sdc_pkg::REQ_LOOKUP: begin
        if (xform_on) begin
          pos    = rank_of(v);
          r.rank = sdc_pkg::CNT_W'(pos);
          r.hit  = (pos < dict_count) && (dict[pos] == v);
        end else begin
          r.rank  = v[sdc_pkg::CNT_W-1:0];
          r.value = v;
        end
      end
      default: begin
        r.rank = sdc_pkg::CNT_W'(ix);
        if (!xform_on) begin
          r.value = sdc_pkg::DATA_W'(ix);
        end else if (ix < dict_count) begin
          r.value = dict[ix];
        end else begin
          r.bad = 1'b1;
        end
      end
    endcase
    r.count = sdc_pkg::CNT_W'(dict_count);
    if (dict_count < (1 << 8)) begin
      r.wcode = sdc_pkg::WIDTH_8;
    end else if (dict_count < (1 << 16)) begin
      r.wcode = sdc_pkg::WIDTH_16;
    end else begin
      r.wcode = sdc_pkg::WIDTH_32;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_count   = 0;
      xform_on     = 1'b1;
      mismatches_o = 0;
      checked_o    = 0;
      pending_q.delete();
    end else begin
      if (done_i) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result with nothing expected, entry_count",
                          sdc_pkg::DATA_W'(entry_count_i), '0);
        end else begin
          oldest = pending_q.pop_front();
          checked_o++;
          if (rank_index_i !== oldest.rank) begin
            report_mismatch("rank_index", sdc_pkg::DATA_W'(rank_index_i),
                            sdc_pkg::DATA_W'(oldest.rank));
          end
          if (table_value_i !== oldest.value) begin
            report_mismatch("table_value", table_value_i, oldest.value);
          end
          if (entry_count_i !== oldest.count) begin
            report_mismatch("entry_count", sdc_pkg::DATA_W'(entry_count_i),
                            sdc_pkg::DATA_W'(oldest.count));
          end
          if (width_code_i !== oldest.wcode) begin
            report_mismatch("width_code", sdc_pkg::DATA_W'(width_code_i),
                            sdc_pkg::DATA_W'(oldest.wcode));
          end
          if (found_i !== oldest.hit) begin
            report_mismatch("found", sdc_pkg::DATA_W'(found_i), sdc_pkg::DATA_W'(oldest.hit));
          end
          if (overflow_i !== oldest.ovf) begin
            report_mismatch("overflow", sdc_pkg::DATA_W'(overflow_i),
                            sdc_pkg::DATA_W'(oldest.ovf));
          end
          if (index_bad_i !== oldest.bad) begin
            report_mismatch("index_bad", sdc_pkg::DATA_W'(index_bad_i),
                            sdc_pkg::DATA_W'(oldest.bad));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        xform_on = cfg_data_i;
      end
      if (start && !busy) begin
        fresh = encode_request(sdc_pkg::req_e'(req_type_i), data_value_i, table_index_i);
        pending_q.insert(pending_q.size(), fresh);
      end
    end
    outstanding_o = pending_q.size();
  end

endmodule

// ===== tb/sorted_dictionary_coder_tb.sv =====
// testbench top for sorted_dictionary_coder: clock, reset, request and
// register stimulus, verdict; checking lives in sorted_dictionary_coder_checker
// depends on sdc_pkg, sorted_dictionary_coder, sorted_dictionary_coder_checker
`timescale 1ns / 100ps

module sorted_dictionary_coder_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [1:0]                 req_type_i;
  logic [sdc_pkg::DATA_W-1:0] data_value_i;
  logic [sdc_pkg::IDX_W-1:0]  table_index_i;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic                       cfg_data_i;
  logic                       done_o;
  logic [sdc_pkg::CNT_W-1:0]  rank_index_o;
  logic [sdc_pkg::DATA_W-1:0] table_value_o;
  logic [sdc_pkg::CNT_W-1:0]  entry_count_o;
  logic [1:0]                 width_code_o;
  logic                       found_o;
  logic                       overflow_o;
  logic                       index_bad_o;

  int unsigned                mismatches;
  int unsigned                outstanding;
  int unsigned                checked;
  int unsigned                cycle_count = 0;
  int unsigned                idle_pct;
  int unsigned                per_kind [4];
  logic [sdc_pkg::DATA_W-1:0] pool [$];

  sorted_dictionary_coder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .data_value_i  (data_value_i),
    .table_index_i (table_index_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .rank_index_o  (rank_index_o),
    .table_value_o (table_value_o),
    .entry_count_o (entry_count_o),
    .width_code_o  (width_code_o),
    .found_o       (found_o),
    .overflow_o    (overflow_o),
    .index_bad_o   (index_bad_o)
  );

  sorted_dictionary_coder_checker i_dict_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .data_value_i  (data_value_i),
    .table_index_i (table_index_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_i        (done_o),
    .rank_index_i  (rank_index_o),
    .table_value_i (table_value_o),
    .entry_count_i (entry_count_o),
    .width_code_i  (width_code_o),
    .found_i       (found_o),
    .overflow_i    (overflow_o),
    .index_bad_i   (index_bad_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic bit in_pool(input logic [sdc_pkg::DATA_W-1:0] v);
    foreach (pool[j]) begin
      if (pool[j] == v) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // random idle cycles with junk on the fields, then hold the item until taken
  task automatic push_request(input sdc_pkg::req_e kind, input logic [sdc_pkg::DATA_W-1:0] v,
                              input logic [sdc_pkg::IDX_W-1:0] ix);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start         <= 1'b0;
      req_type_i    <= 2'($urandom);
      data_value_i  <= $urandom;
      table_index_i <= sdc_pkg::IDX_W'($urandom);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= kind;
    data_value_i  <= v;
    table_index_i <= ix;
    do begin
      @(posedge clk_i);
    end while (busy);
    per_kind[kind]++;
    if (kind == sdc_pkg::REQ_CLEAR) begin
      pool.delete();
    end else if (kind == sdc_pkg::REQ_INSERT && pool.size() < sdc_pkg::TABLE_DEPTH) begin
      if (!in_pool(v)) begin
        pool.insert(pool.size(), v);
      end
    end
  endtask

  task automatic drain;
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_transform(input logic on);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed traffic around the values already held, some noise
  task automatic random_request;
    sdc_pkg::req_e              kind;
    logic [sdc_pkg::DATA_W-1:0] v;
    logic [sdc_pkg::IDX_W-1:0]  ix;
    int unsigned                pick;
    int unsigned                top;
    pick = $urandom_range(99);
    if (pick < 7) begin
      push_request(sdc_pkg::req_e'($urandom_range(3)), $urandom, sdc_pkg::IDX_W'($urandom));
    end else begin
      if (pick < 10) begin
        kind = sdc_pkg::REQ_CLEAR;
      end else if (pick < 45) begin
        kind = sdc_pkg::REQ_INSERT;
      end else if (pick < 75) begin
        kind = sdc_pkg::REQ_LOOKUP;
      end else begin
        kind = sdc_pkg::REQ_INVERSE;
      end
      v = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3: if (pool.size() != 0) v = pool[$urandom_range(pool.size() - 1)];
        4:          if (pool.size() != 0) v = pool[$urandom_range(pool.size() - 1)] + 1;
        5:          if (pool.size() != 0) v = pool[$urandom_range(pool.size() - 1)] - 1;
        6:          v = $urandom_range(15);
        7: begin
          case ($urandom_range(2))
            0:       v = '0;
            1:       v = '1;
            default: v = 32'h8000_0000;
          endcase
        end
        default: ;
      endcase
      top = pool.size() + 1;
      if (top > sdc_pkg::TABLE_DEPTH - 1) begin
        top = sdc_pkg::TABLE_DEPTH - 1;
      end
      if ($urandom_range(3) != 0) begin
        ix = sdc_pkg::IDX_W'($urandom_range(top));
      end else begin
        ix = sdc_pkg::IDX_W'($urandom);
      end
      push_request(kind, v, ix);
    end
  endtask

  initial begin
    logic [21:0] hi_bits;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = '0;
    data_value_i  = '0;
    table_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    idle_pct      = 0;
    per_kind      = '{default: 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, transform on from reset
    push_request(sdc_pkg::REQ_LOOKUP, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'hFFFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'h8000_0000, 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'h8000_0001, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd2);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd3);
    push_request(sdc_pkg::REQ_INVERSE, 32'hFFFF_FFFF, 10'd1023);
    drain();
    write_transform(1'b0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'h0000_0A5C, 10'd1023);
    push_request(sdc_pkg::REQ_INVERSE, 32'hFFFF_FFFF, 10'd1023);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'h5, 10'd0);
    push_request(sdc_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 10'd1023);
    drain();
    write_transform(1'b1);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_CLEAR, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, 32'h1234_5678, 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'h1234_5678, 10'd0);
    push_request(sdc_pkg::REQ_CLEAR, 32'h0, 10'd0);
    drain();

    // random phases, each with its own idling and transform setting
    idle_pct = 23;
    repeat (200) random_request();
    drain();
    write_transform(1'b0);
    idle_pct = 87;
    repeat (120) random_request();
    drain();
    write_transform(1'b1);
    idle_pct = 0;
    repeat (180) random_request();

    // fill the table to its depth in random order, then push past it
    push_request(sdc_pkg::REQ_CLEAR, 32'h0, 10'd0);
    for (int n = 0; n < sdc_pkg::TABLE_DEPTH; n++) begin
      hi_bits = 22'($urandom);
      push_request(sdc_pkg::REQ_INSERT, {hi_bits, sdc_pkg::IDX_W'(n)},
                   sdc_pkg::IDX_W'($urandom));
      if (n % 64 == 63) begin
        push_request(sdc_pkg::REQ_LOOKUP, $urandom, sdc_pkg::IDX_W'($urandom));
      end
    end
    repeat (3) push_request(sdc_pkg::REQ_INSERT, $urandom, 10'd0);
    push_request(sdc_pkg::REQ_INSERT, pool[5], 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, pool[0], 10'd0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd1023);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    drain();
    write_transform(1'b0);
    push_request(sdc_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd1023);
    push_request(sdc_pkg::REQ_INSERT, 32'hFFFF_FFFE, 10'd0);
    drain();
    write_transform(1'b1);
    push_request(sdc_pkg::REQ_CLEAR, 32'h0, 10'd0);
    push_request(sdc_pkg::REQ_INVERSE, 32'h0, 10'd0);
    drain();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("requests sent: %0d clear, %0d insert, %0d lookup, %0d inverse; %0d checked",
             per_kind[sdc_pkg::REQ_CLEAR], per_kind[sdc_pkg::REQ_INSERT],
             per_kind[sdc_pkg::REQ_LOOKUP], per_kind[sdc_pkg::REQ_INVERSE], checked);
    $display("transform on and off, table filled to all %0d entries and pushed past full",
             sdc_pkg::TABLE_DEPTH);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
